/* rtl/prd_pkg.sv */
package prd_pkg;

  localparam int unsigned WindowDef   = 10;
  localparam int unsigned HistoryDef  = 5;
  localparam int unsigned LedCountDef = 12;

  localparam logic [2:0] RegRiseThreshold = 3'd0;
  localparam logic [2:0] RegRefractory    = 3'd1;
  localparam logic [2:0] RegAlpha         = 3'd2;
  localparam logic [2:0] RegBarLow        = 3'd3;
  localparam logic [2:0] RegBarHigh       = 3'd4;
  localparam logic [2:0] RegBeepMin       = 3'd5;
  localparam logic [2:0] RegBeepLength    = 3'd6;

  localparam logic [31:0] MsPerMinute = 32'd60000;

  typedef struct packed {
    logic [9:0]  sample;
    logic [31:0] now_ms;
  } in_t;

  typedef struct packed {
    logic [9:0] filtered_level;
    logic       beat;
    logic [7:0] beat_rate;
    logic [7:0] shown_rate;
    logic [3:0] leds_lit;
    logic       beeper_on;
  } out_t;

  typedef struct packed {
    logic [9:0]  rise_threshold;
    logic [15:0] refractory_ms;
    logic [8:0]  smoothing_alpha;
    logic [7:0]  bar_low_rate;
    logic [7:0]  bar_high_rate;
    logic [7:0]  beep_min_rate;
    logic [9:0]  beep_length_ms;
  } cfg_t;

  // classified item handed from front to back
  typedef struct packed {
    logic [9:0]  level;
    logic        rise;
    logic [31:0] now_ms;
  } job_t;

endpackage

/* rtl/prd_front.sv */
module prd_front #(
  parameter int unsigned Window = prd_pkg::WindowDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  prd_pkg::in_t  in_i,
  input  logic          take_i,
  input  logic [9:0]    rise_threshold_i,
  output prd_pkg::job_t job_o
);
  import prd_pkg::*;

  localparam int unsigned SlotW  = (Window > 1) ? $clog2(Window) : 1;
  localparam int unsigned TotalW = 10 + $clog2(Window + 1);
  localparam int unsigned Shift  = TotalW + $clog2(Window);
  localparam int unsigned ProdW  = TotalW + Shift + 1;
  localparam longint unsigned Recip = ((64'd1 << Shift) + Window - 1) / Window;

  logic [9:0]        ring_q [Window];
  logic [SlotW-1:0]  slot_q;
  logic [TotalW-1:0] total_q, total_d;
  logic [ProdW-1:0]  prod;
  logic [9:0]        prev_q, level_d;
  logic [10:0]       diff;

  assign total_d = total_q - TotalW'(ring_q[slot_q]) + TotalW'(in_i.sample);
  // mean by reciprocal multiplication, exact over the whole total range
  assign prod    = ProdW'(total_d) * ProdW'(Recip);
  assign level_d = 10'(prod >> Shift);
  assign diff    = {1'b0, level_d} - {1'b0, prev_q};

  assign job_o.level  = level_d;
  assign job_o.rise   = !diff[10] && (diff[9:0] > rise_threshold_i);
  assign job_o.now_ms = in_i.now_ms;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Window; i++) ring_q[i] <= '0;
      slot_q  <= '0;
      total_q <= '0;
      prev_q  <= '0;
    end else if (take_i) begin
      ring_q[slot_q] <= in_i.sample;
      slot_q  <= (slot_q == SlotW'(Window - 1)) ? '0 : slot_q + 1'b1;
      total_q <= total_d;
      prev_q  <= level_d;
    end
  end

endmodule

/* rtl/prd_div.sv */
module prd_div (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        start_i,
  input  logic [31:0] num_i,
  input  logic [31:0] den_i,
  output logic        busy_o,
  output logic [31:0] quo_o
);
  import prd_pkg::*;

  logic [31:0] quo_q, rem_q, den_q;
  logic [5:0]  cnt_q;
  logic [32:0] trial;

  assign trial  = {rem_q, quo_q[31]} - {1'b0, den_q};
  assign busy_o = cnt_q != '0;
  assign quo_o  = quo_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      quo_q <= '0;
      rem_q <= '0;
      den_q <= '0;
    end else if (start_i) begin
      cnt_q <= 6'd32;
      quo_q <= num_i;
      rem_q <= '0;
      den_q <= den_i;
    end else if (busy_o) begin
      cnt_q <= cnt_q - 1'b1;
      if (!trial[32]) begin
        rem_q <= trial[31:0];
        quo_q <= {quo_q[30:0], 1'b1};
      end else begin
        rem_q <= {rem_q[30:0], quo_q[31]};
        quo_q <= {quo_q[30:0], 1'b0};
      end
    end
  end

endmodule

/* rtl/prd_back.sv */
module prd_back #(
  parameter int unsigned History  = prd_pkg::HistoryDef,
  parameter int unsigned LedCount = prd_pkg::LedCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          job_valid_i,
  input  prd_pkg::job_t job_i,
  output logic          job_take_o,
  input  prd_pkg::cfg_t cfg_i,
  output logic          res_valid_o,
  input  logic          res_stall_i,
  output prd_pkg::out_t res_o
);
  import prd_pkg::*;

  localparam int unsigned HSlotW = (History > 1) ? $clog2(History) : 1;
  localparam int unsigned CntW   = $clog2(History + 1);
  localparam int unsigned SumW   = 8 + CntW;

  localparam logic [3:0] StIdle  = 4'd0;
  localparam logic [3:0] StRate  = 4'd1;
  localparam logic [3:0] StHist  = 4'd2;
  localparam logic [3:0] StMean  = 4'd3;
  localparam logic [3:0] StMul1  = 4'd4;
  localparam logic [3:0] StMul2  = 4'd5;
  localparam logic [3:0] StPer   = 4'd6;
  localparam logic [3:0] StBar   = 4'd7;
  localparam logic [3:0] StBeep  = 4'd8;
  localparam logic [3:0] StOut   = 4'd9;
  localparam logic [3:0] StDivW  = 4'd10;

  logic [3:0]  state_q, ret_q;
  job_t        job_q;
  logic        beat_q;
  logic [7:0]  held_q;
  logic [31:0] last_beat_q, last_tog_q;
  logic [7:0]  hist_q [History];
  logic [HSlotW-1:0] hslot_q;
  logic [HSlotW:0]   hidx_q;
  logic [SumW-1:0]   sum_q;
  logic [CntW-1:0]   cnt_q;
  logic [15:0] smooth_q;
  logic [25:0] acc_q;
  logic [7:0]  shown_q;
  logic [31:0] period_q;
  logic        beep_q;
  logic [3:0]  leds_q;
  logic        res_valid_q;
  out_t        res_q;

  logic        div_start, div_busy;
  logic [31:0] div_num, div_den, div_quo;

  prd_div u_div (
    .clk_i,
    .rst_ni,
    .start_i (div_start),
    .num_i   (div_num),
    .den_i   (div_den),
    .busy_o  (div_busy),
    .quo_o   (div_quo)
  );

  logic [31:0] interval;
  logic [8:0]  alpha;
  logic [31:0] since;
  logic [31:0] gap;
  logic [8:0]  span;
  logic signed [9:0] off;
  logic [7:0]  off_mag, span_mag;
  logic        res_load;

  assign interval = job_q.now_ms - last_beat_q;
  assign alpha    = (cfg_i.smoothing_alpha > 9'd256) ? 9'd256 : cfg_i.smoothing_alpha;
  assign since    = job_q.now_ms - last_tog_q;
  assign gap      = (period_q > 32'(cfg_i.beep_length_ms))
                    ? period_q - 32'(cfg_i.beep_length_ms) : '0;
  assign span     = {1'b0, cfg_i.bar_high_rate} - {1'b0, cfg_i.bar_low_rate};
  assign off      = $signed({2'b0, shown_q}) - $signed({2'b0, cfg_i.bar_low_rate});
  assign off_mag  = off[9] ? 8'(-off) : off[7:0];
  assign span_mag = span[8] ? 8'(9'd0 - span) : span[7:0];
  assign res_load = (state_q == StBeep) && (!res_valid_q || !res_stall_i);

  assign job_take_o  = (state_q == StIdle) && job_valid_i;
  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

  always_comb begin
    div_start = 1'b0;
    div_num   = '0;
    div_den   = '0;
    unique case (state_q)
      StRate: begin
        div_start = job_q.rise && (interval > 32'(cfg_i.refractory_ms));
        div_num   = MsPerMinute;
        div_den   = interval;
      end
      StMean: begin
        div_start = cnt_q != '0;
        div_num   = 32'(sum_q) << 8;
        div_den   = 32'(cnt_q);
      end
      StPer: begin
        div_start = shown_q > cfg_i.beep_min_rate;
        div_num   = MsPerMinute;
        div_den   = 32'(shown_q);
      end
      StBar: begin
        div_start = (span != '0) && (span[8] == off[9]);
        div_num   = 32'(off_mag) * 32'(LedCount);
        div_den   = 32'(span_mag);
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      ret_q       <= StIdle;
      beat_q      <= 1'b0;
      held_q      <= '0;
      last_beat_q <= '0;
      last_tog_q  <= '0;
      for (int i = 0; i < History; i++) hist_q[i] <= '0;
      hslot_q     <= '0;
      hidx_q      <= '0;
      sum_q       <= '0;
      cnt_q       <= '0;
      smooth_q    <= '0;
      acc_q       <= '0;
      shown_q     <= '0;
      period_q    <= '0;
      beep_q      <= 1'b0;
      leds_q      <= '0;
      res_valid_q <= 1'b0;
      job_q       <= '0;
      res_q       <= '0;
    end else begin
      if (res_load) res_valid_q <= 1'b1;
      else if (!res_stall_i) res_valid_q <= 1'b0;
      unique case (state_q)
        StIdle: begin
          if (job_valid_i) begin
            job_q   <= job_i;
            beat_q  <= 1'b0;
            state_q <= StRate;
          end
        end
        StRate: begin
          if (div_start) begin
            state_q <= StDivW;
            ret_q   <= StRate;
            beat_q  <= 1'b1;
            job_q.rise <= 1'b0;
          end else begin
            if (beat_q) begin
              held_q          <= (div_quo > 32'd255) ? 8'd255 : div_quo[7:0];
              hist_q[hslot_q] <= (div_quo > 32'd255) ? 8'd255 : div_quo[7:0];
              hslot_q     <= (hslot_q == HSlotW'(History - 1)) ? '0 : hslot_q + 1'b1;
              last_beat_q <= job_q.now_ms;
            end
            hidx_q  <= '0;
            sum_q   <= '0;
            cnt_q   <= '0;
            state_q <= StHist;
          end
        end
        StHist: begin
          if (hidx_q == (HSlotW+1)'(History)) begin
            state_q <= StMean;
          end else begin
            if (hist_q[hidx_q[HSlotW-1:0]] != '0) begin
              sum_q <= sum_q + SumW'(hist_q[hidx_q[HSlotW-1:0]]);
              cnt_q <= cnt_q + 1'b1;
            end
            hidx_q <= hidx_q + 1'b1;
          end
        end
        StMean: begin
          if (div_start) begin
            state_q <= StDivW;
            ret_q   <= StMul1;
          end else begin
            state_q <= StPer;
            shown_q <= smooth_q[15:8];
          end
        end
        StMul1: begin
          acc_q   <= 26'(alpha) * 26'(div_quo[16:0]);
          state_q <= StMul2;
        end
        StMul2: begin
          smooth_q <= 16'((acc_q + 26'(9'd256 - alpha) * 26'(smooth_q)) >> 8);
          shown_q  <= 8'((acc_q + 26'(9'd256 - alpha) * 26'(smooth_q)) >> 16);
          state_q  <= StPer;
        end
        StPer: begin
          if (div_start) begin
            state_q <= StDivW;
            ret_q   <= StBar;
          end else begin
            period_q <= '0;
            state_q  <= StBar;
          end
          if (!div_start) begin
            beep_q     <= 1'b0;
            last_tog_q <= '0;
          end
        end
        StBar: begin
          if (shown_q > cfg_i.beep_min_rate) period_q <= div_quo;
          if (span == '0) begin
            leds_q  <= (shown_q >= cfg_i.bar_low_rate) ? 4'(LedCount) : '0;
            state_q <= StBeep;
          end else if (span[8] != off[9]) begin
            leds_q  <= '0;
            state_q <= StBeep;
          end else begin
            state_q <= StDivW;
            ret_q   <= StOut;
          end
        end
        StOut: begin
          leds_q  <= (div_quo > 32'(LedCount)) ? 4'(LedCount) : div_quo[3:0];
          state_q <= StBeep;
        end
        StBeep: begin
          if (res_load) begin
            if (shown_q > cfg_i.beep_min_rate) begin
              if (beep_q) begin
                if (since >= 32'(cfg_i.beep_length_ms)) begin
                  beep_q     <= 1'b0;
                  last_tog_q <= job_q.now_ms;
                end
              end else if (since >= gap) begin
                beep_q     <= 1'b1;
                last_tog_q <= job_q.now_ms;
              end
            end
            res_q.filtered_level <= job_q.level;
            res_q.beat           <= beat_q;
            res_q.beat_rate      <= held_q;
            res_q.shown_rate     <= shown_q;
            res_q.leds_lit       <= leds_q;
            res_q.beeper_on      <= (shown_q > cfg_i.beep_min_rate) &&
                                    (beep_q ? !(since >= 32'(cfg_i.beep_length_ms))
                                            : (since >= gap));
            state_q              <= StIdle;
          end
        end
        StDivW: begin
          if (!div_busy) state_q <= ret_q;
        end
        default: state_q <= StIdle;
      endcase
    end
  end

endmodule

/* rtl/pulse_rate_detector.sv */
// channel  direction  handshake                payload
// in       input      in_valid_i/in_stall_o    prd_pkg::in_t
// out      output     out_valid_o/out_stall_i  prd_pkg::out_t
// cfg      input      cfg_valid_i/cfg_ready_o  index, data
// an item's divisions on the shared 32-step divider
// (beat rate, history mean, beep period, bar scale) run one after another
// reset clears all history; the front filter updates as each item is queued
// a two-entry queue parts the filter from the rate sequencer; the result
// register frees the sequencer once the waiting result is taken
module pulse_rate_detector #(
  parameter int unsigned Window   = prd_pkg::WindowDef,
  parameter int unsigned History  = prd_pkg::HistoryDef,
  parameter int unsigned LedCount = prd_pkg::LedCountDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  prd_pkg::in_t  in_data_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output prd_pkg::out_t out_data_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic [2:0]    cfg_index_i,
  input  logic [31:0]   cfg_data_i
);
  import prd_pkg::*;

  cfg_t  cfg_q;
  job_t  front_job;
  job_t  fifo_q [2];
  logic  rd_q, wr_q;
  logic [1:0] fill_q;
  logic  take, job_take;

  assign cfg_ready_o = 1'b1;
  assign in_stall_o  = fill_q == 2'd2;
  assign take        = in_valid_i && !in_stall_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rise_threshold  <= 10'd1;
      cfg_q.refractory_ms   <= 16'd400;
      cfg_q.smoothing_alpha <= 9'd51;
      cfg_q.bar_low_rate    <= 8'd40;
      cfg_q.bar_high_rate   <= 8'd140;
      cfg_q.beep_min_rate   <= 8'd40;
      cfg_q.beep_length_ms  <= 10'd50;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        RegRiseThreshold: cfg_q.rise_threshold  <= cfg_data_i[9:0];
        RegRefractory:    cfg_q.refractory_ms   <= cfg_data_i[15:0];
        RegAlpha:         cfg_q.smoothing_alpha <= cfg_data_i[8:0];
        RegBarLow:        cfg_q.bar_low_rate    <= cfg_data_i[7:0];
        RegBarHigh:       cfg_q.bar_high_rate   <= cfg_data_i[7:0];
        RegBeepMin:       cfg_q.beep_min_rate   <= cfg_data_i[7:0];
        RegBeepLength:    cfg_q.beep_length_ms  <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

  prd_front #(.Window(Window)) u_front (
    .clk_i,
    .rst_ni,
    .in_i             (in_data_i),
    .take_i           (take),
    .rise_threshold_i (cfg_q.rise_threshold),
    .job_o            (front_job)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_q   <= 1'b0;
      wr_q   <= 1'b0;
      fill_q <= '0;
      fifo_q[0] <= '0;
      fifo_q[1] <= '0;
    end else begin
      if (take) begin
        fifo_q[wr_q] <= front_job;
        wr_q <= !wr_q;
      end
      if (job_take) rd_q <= !rd_q;
      fill_q <= fill_q + {1'b0, take} - {1'b0, job_take};
    end
  end

  prd_back #(.History(History), .LedCount(LedCount)) u_back (
    .clk_i,
    .rst_ni,
    .job_valid_i (fill_q != '0),
    .job_i       (fifo_q[rd_q]),
    .job_take_o  (job_take),
    .cfg_i       (cfg_q),
    .res_valid_o (out_valid_o),
    .res_stall_i (out_stall_i),
    .res_o       (out_data_o)
  );

endmodule

/* sim/tb_pulse_rate_detector.sv */
`timescale 1ns / 1ps

class pulse_scoreboard;
  prd_pkg::cfg_t cfg;
  bit [9:0]  level_ring [10];
  int unsigned level_slot;
  int unsigned level_total;
  int unsigned prev_level;
  bit [31:0] last_beat_ms;
  int unsigned rate_ring [5];
  int unsigned rate_slot;
  int unsigned smooth_q88;
  int unsigned held_rate;
  bit          beeping;
  bit [31:0] last_toggle_ms;
  prd_pkg::out_t expected_q[$];
  int errors;

  function new();
    cfg.rise_threshold  = 10'd1;
    cfg.refractory_ms   = 16'd400;
    cfg.smoothing_alpha = 9'd51;
    cfg.bar_low_rate    = 8'd40;
    cfg.bar_high_rate   = 8'd140;
    cfg.beep_min_rate   = 8'd40;
    cfg.beep_length_ms  = 10'd50;
    foreach (level_ring[i]) level_ring[i] = '0;
    foreach (rate_ring[i]) rate_ring[i] = 0;
    level_slot = 0;
    level_total = 0;
    prev_level = 0;
    last_beat_ms = '0;
    rate_slot = 0;
    smooth_q88 = 0;
    held_rate = 0;
    beeping = 1'b0;
    last_toggle_ms = '0;
    errors = 0;
  endfunction

  function void set_reg(logic [2:0] idx, logic [31:0] val);
    case (idx)
      prd_pkg::RegRiseThreshold: cfg.rise_threshold  = val[9:0];
      prd_pkg::RegRefractory:    cfg.refractory_ms   = val[15:0];
      prd_pkg::RegAlpha:         cfg.smoothing_alpha = val[8:0];
      prd_pkg::RegBarLow:        cfg.bar_low_rate    = val[7:0];
      prd_pkg::RegBarHigh:       cfg.bar_high_rate   = val[7:0];
      prd_pkg::RegBeepMin:       cfg.beep_min_rate   = val[7:0];
      prd_pkg::RegBeepLength:    cfg.beep_length_ms  = val[9:0];
      default: ;
    endcase
  endfunction

  function int unsigned bar_leds(int unsigned shown);
    int lo;
    int hi;
    int v;
    lo = cfg.bar_low_rate;
    hi = cfg.bar_high_rate;
    if (hi == lo) return (shown >= lo) ? 12 : 0;
    v = (int'(shown) - lo) * 12 / (hi - lo);
    if (v < 0) v = 0;
    if (v > 12) v = 12;
    return v;
  endfunction

  function void note_input(prd_pkg::in_t item);
    int unsigned lvl;
    int unsigned sum;
    int unsigned cnt;
    int unsigned mean;
    int unsigned alpha;
    int unsigned shown;
    int unsigned period;
    int unsigned gap;
    bit [31:0]   interval;
    bit [31:0]   since;
    bit          beat;
    prd_pkg::out_t res;
    beat = 1'b0;
    level_total = level_total - level_ring[level_slot] + item.sample;
    level_ring[level_slot] = item.sample;
    level_slot = (level_slot + 1) % 10;
    lvl = level_total / 10;
    if (int'(lvl) - int'(prev_level) > int'(cfg.rise_threshold)) begin
      interval = item.now_ms - last_beat_ms;
      if (interval > cfg.refractory_ms) begin
        held_rate = 60000 / interval;
        if (held_rate > 255) held_rate = 255;
        last_beat_ms = item.now_ms;
        rate_ring[rate_slot] = held_rate;
        rate_slot = (rate_slot + 1) % 5;
        beat = 1'b1;
      end
    end
    prev_level = lvl;
    sum = 0;
    cnt = 0;
    foreach (rate_ring[i]) begin
      if (rate_ring[i] != 0) begin
        sum += rate_ring[i];
        cnt++;
      end
    end
    if (cnt > 0) begin
      mean = (sum << 8) / cnt;
      alpha = (cfg.smoothing_alpha > 256) ? 256 : cfg.smoothing_alpha;
      smooth_q88 = ((alpha * mean + (256 - alpha) * smooth_q88) >> 8) & 32'hFFFF;
    end
    shown = (smooth_q88 >> 8) & 8'hFF;
    if (shown > cfg.beep_min_rate) begin
      period = 60000 / shown;
      since = item.now_ms - last_toggle_ms;
      if (beeping) begin
        if (since >= cfg.beep_length_ms) begin
          beeping = 1'b0;
          last_toggle_ms = item.now_ms;
        end
      end else begin
        gap = (period > cfg.beep_length_ms) ? period - cfg.beep_length_ms : 0;
        if (since >= gap) begin
          beeping = 1'b1;
          last_toggle_ms = item.now_ms;
        end
      end
    end else begin
      beeping = 1'b0;
      last_toggle_ms = '0;
    end
    res.filtered_level = lvl[9:0];
    res.beat           = beat;
    res.beat_rate      = held_rate[7:0];
    res.shown_rate     = shown[7:0];
    res.leds_lit       = 4'(bar_leds(shown));
    res.beeper_on      = beeping;
    expected_q.push_back(res);
  endfunction

  function void check_result(prd_pkg::out_t got);
    prd_pkg::out_t exp_res;
    if (expected_q.size() == 0) begin
      $error("unexpected result transaction %h", got);
      errors++;
      return;
    end
    exp_res = expected_q.pop_front();
    if (got.filtered_level !== exp_res.filtered_level) begin
      $error("filtered_level: expected %0d, got %0d", exp_res.filtered_level,
             got.filtered_level);
      errors++;
    end
    if (got.beat !== exp_res.beat) begin
      $error("beat: expected %0d, got %0d", exp_res.beat, got.beat);
      errors++;
    end
    if (got.beat_rate !== exp_res.beat_rate) begin
      $error("beat_rate: expected %0d, got %0d", exp_res.beat_rate, got.beat_rate);
      errors++;
    end
    if (got.shown_rate !== exp_res.shown_rate) begin
      $error("shown_rate: expected %0d, got %0d", exp_res.shown_rate, got.shown_rate);
      errors++;
    end
    if (got.leds_lit !== exp_res.leds_lit) begin
      $error("leds_lit: expected %0d, got %0d", exp_res.leds_lit, got.leds_lit);
      errors++;
    end
    if (got.beeper_on !== exp_res.beeper_on) begin
      $error("beeper_on: expected %0d, got %0d", exp_res.beeper_on, got.beeper_on);
      errors++;
    end
  endfunction
endclass

module tb_pulse_rate_detector;
  import prd_pkg::*;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  in_t         in_data_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  out_t        out_data_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [31:0] cfg_data_i = '0;

  pulse_scoreboard sb;
  int          idle_mode;
  int          hold_request;
  int          hold_left = 0;
  bit          hold_taken = 1'b0;
  bit [31:0]   clock_ms;

  pulse_rate_detector u_top (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i)
  );

  always #5 clk_i = ~clk_i;

  initial begin
    #50ms;
    $display("end of test: mismatches");
    $finish;
  end

  // result side: check each transaction, then choose next stall
  always @(posedge clk_i) begin
    if (!rst_ni) begin
      out_stall_i <= 1'b0;
    end else begin
      if (out_valid_o && !out_stall_i) sb.check_result(out_data_o);
      if (hold_request > 0 && !hold_taken) begin
        hold_left = hold_request;
        hold_taken = 1'b1;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_stall_i <= 1'b1;
      end else if (idle_mode == 2) begin
        out_stall_i <= ($urandom_range(99) < 82);
      end else if (idle_mode == 3) begin
        out_stall_i <= ($urandom_range(99) < 16);
      end else begin
        out_stall_i <= 1'b0;
      end
    end
  end

  task automatic write_reg(logic [2:0] idx, logic [31:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    sb.set_reg(idx, val);
  endtask

  task automatic send_sample(logic [9:0] smp, logic [31:0] now);
    int gap;
    gap = 0;
    if (idle_mode == 1 && $urandom_range(99) < 82) gap = $urandom_range(12, 1);
    if (idle_mode == 3 && $urandom_range(99) < 16) gap = $urandom_range(6, 1);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i  <= '{sample: smp, now_ms: now};
    do @(posedge clk_i); while (in_stall_o);
    sb.note_input('{sample: smp, now_ms: now});
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.expected_q.size() > 0) @(posedge clk_i);
    repeat (400) @(posedge clk_i);
  endtask

  task automatic write_all(int t, int r, int a, int lo, int hi, int bm, int bl);
    write_reg(RegRiseThreshold, t);
    write_reg(RegRefractory, r);
    write_reg(RegAlpha, a);
    write_reg(RegBarLow, lo);
    write_reg(RegBarHigh, hi);
    write_reg(RegBeepMin, bm);
    write_reg(RegBeepLength, bl);
  endtask

  // heartbeat-like waveform with random shape, plus some noise transactions
  task automatic send_rhythm(int count);
    int base;
    int amp;
    int beat_len;
    int width;
    int pos;
    int val;
    base = $urandom_range(600);
    amp = $urandom_range(420, 40);
    beat_len = $urandom_range(60, 12);
    width = $urandom_range(8, 1);
    pos = 0;
    for (int n = 0; n < count; n++) begin
      if ($urandom_range(99) < 10) begin
        case ($urandom_range(3))
          0: clock_ms = $urandom;
          1: clock_ms += $urandom_range(70000, 1);
          default: clock_ms += $urandom_range(40);
        endcase
        send_sample(10'($urandom_range(1023)), clock_ms);
      end else begin
        clock_ms += ($urandom_range(9) == 0) ? $urandom_range(60, 1) : 20;
        val = base + ((pos < width) ? amp : 0) + $urandom_range(15);
        if (val > 1023) val = 1023;
        send_sample(10'(val), clock_ms);
        pos = (pos + 1) % beat_len;
        if ($urandom_range(199) == 0) beat_len = $urandom_range(60, 12);
      end
    end
  endtask

  initial begin
    sb = new();
    idle_mode = 0;
    hold_request = 0;
    clock_ms = '0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed: saturated rate, zero rate, wrap, alpha above range, equal bar ends
    write_all(1, 0, 511, 100, 100, 0, 0);
    send_sample(10'd1023, 32'd1);
    send_sample(10'd1023, 32'd2);
    send_sample(10'd1023, 32'd3);
    send_sample(10'd0, 32'd4);
    send_sample(10'd0, 32'd5);
    send_sample(10'd1023, 32'd70000);
    send_sample(10'd1023, 32'hFFFF_FFF0);
    send_sample(10'd1023, 32'hFFFF_FFFF);
    send_sample(10'd1023, 32'd0);
    send_sample(10'd1023, 32'd600);
    for (int k = 0; k < 10; k++) send_sample(10'd0, 32'd700 + k);
    send_sample(10'd1023, 32'd1500);
    send_sample(10'd1023, 32'd2300);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      idle_mode = ph % 4;
      case (ph)
        0: write_all(1023, 65535, 256, 255, 255, 255, 1023);
        1: write_all(0, 0, 0, 0, 0, 0, 0);
        2: write_all(1, 400, 51, 40, 140, 40, 50);
        default: write_all($urandom_range(30), $urandom_range(700, 150),
                           $urandom_range(511), $urandom_range(100),
                           $urandom_range(255), $urandom_range(120),
                           $urandom_range(1023));
      endcase
      if (ph == 5) clock_ms = 32'hFFFF_F000;
      else clock_ms = $urandom;
      send_rhythm(120);
      if (ph == 3) begin
        hold_request = 2000;
        send_rhythm(10);
      end
      drain();
      send_rhythm(70);
      drain();
    end

    if (sb.errors == 0 && sb.expected_q.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end
endmodule

/* pulse_rate_detector.f */
rtl/prd_pkg.sv
rtl/prd_front.sv
rtl/prd_div.sv
rtl/prd_back.sv
rtl/pulse_rate_detector.sv
sim/tb_pulse_rate_detector.sv
